### hw/rtl/nbge_pkg.sv
// Shared types, widths and constants of the n-body gravity Euler step block.
package nbge_pkg;

  // Field widths.
  localparam int COORD_W = 48;
  localparam int MASS_W  = 32;
  localparam int FORCE_W = 64;

  // Shared multiplier: A x B, B consumed one byte per cycle.
  localparam int MUL_A_W     = 96;
  localparam int MUL_B_W     = 64;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int MUL_DIGIT_W = 8;
  localparam int MUL_STEPS   = MUL_B_W / MUL_DIGIT_W;

  // Shared divider: one quotient bit per cycle, quotient saturates at 64 bits.
  localparam int DIV_N_W = 145;
  localparam int DIV_D_W = 99;
  localparam int DIV_Q_W = 64;

  // Square root of the squared distance.
  localparam int ROOT_V_W = 98;
  localparam int ROOT_W   = 49;

  // Softening term, 1e-8 in Q48.48.
  localparam logic [DIV_D_W-1:0] EPS_Q48 = 99'd2814750;

  // Register reset values.
  localparam logic [31:0] GRAV_RESET = 32'd10066330;
  localparam logic [23:0] STEP_RESET = 24'd167772;

  // Register indexes.
  localparam logic REG_GRAV = 1'b0;
  localparam logic REG_STEP = 1'b1;

  // Commands.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SOURCE = 1'b1;

  // Kind of a queued item after classification.
  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_ACCUM,
    KIND_FINAL
  } kind_t;

  typedef struct packed {
    logic                      command;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] vel_x;
    logic signed [COORD_W-1:0] vel_y;
    logic signed [COORD_W-1:0] vel_z;
    logic [MASS_W-1:0]         body_mass;
    logic                      last_source;
  } body_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_y;
    logic signed [COORD_W-1:0] new_z;
    logic signed [COORD_W-1:0] new_vx;
    logic signed [COORD_W-1:0] new_vy;
    logic signed [COORD_W-1:0] new_vz;
  } update_t;

  typedef struct packed {
    kind_t                    kind;
    logic [2:0][COORD_W-1:0]  pos;
    logic [2:0][COORD_W-1:0]  vel;
    logic [MASS_W-1:0]        mass;
  } item_t;

  typedef struct packed {
    logic [31:0] grav;
    logic [23:0] step;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                start;
    logic [ROOT_V_W-1:0] val;
  } root_req_t;

endpackage

### hw/rtl/nbge_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
module nbge_front #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  nbge_pkg::body_t body,
  input  logic            q_pop,
  output logic            q_empty,
  output nbge_pkg::item_t q_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  nbge_pkg::item_t  slots [DEPTH];
  nbge_pkg::item_t  in_item;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_acc;
  logic             pop_acc;

  // Classify the incoming item.
  always_comb begin
    in_item.pos[0] = body.pos_x;
    in_item.pos[1] = body.pos_y;
    in_item.pos[2] = body.pos_z;
    in_item.vel[0] = body.vel_x;
    in_item.vel[1] = body.vel_y;
    in_item.vel[2] = body.vel_z;
    in_item.mass   = body.body_mass;
    if (body.command == nbge_pkg::CMD_LOAD) begin
      in_item.kind = nbge_pkg::KIND_LOAD;
    end else if (body.last_source) begin
      in_item.kind = nbge_pkg::KIND_FINAL;
    end else begin
      in_item.kind = nbge_pkg::KIND_ACCUM;
    end
  end

  assign full     = (count == CNT_W'(DEPTH));
  assign q_empty  = (count == '0);
  assign q_item   = slots[rd_ptr];
  assign push_acc = push && !full;
  assign pop_acc  = q_pop && !q_empty;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push_acc) begin
      slots[wr_ptr] <= in_item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_acc) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_acc) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_acc && !pop_acc) begin
        count <= count + 1'b1;
      end else if (pop_acc && !push_acc) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (push_acc && !pop_acc && q_empty) |=> !q_empty)
    else $error("queued item not visible to back end");

endmodule

### hw/rtl/nbge_mul.sv
// Shared multiplier: 96 x 64 bits, one byte of the second operand per cycle.
module nbge_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  nbge_pkg::mul_req_t                  req,
  output logic                                done,
  output logic [nbge_pkg::MUL_P_W-1:0]        prod
);

  localparam int CNT_W  = $clog2(nbge_pkg::MUL_STEPS + 1);
  localparam int PART_W = nbge_pkg::MUL_A_W + nbge_pkg::MUL_DIGIT_W;

  logic                             busy;
  logic [CNT_W-1:0]                 cnt;
  logic [nbge_pkg::MUL_A_W-1:0]     a_r;
  logic [nbge_pkg::MUL_B_W-1:0]     b_r;
  logic [nbge_pkg::MUL_P_W-1:0]     acc;
  logic [PART_W-1:0]                part;

  // One partial product per cycle, top byte first.
  assign part = a_r * b_r[nbge_pkg::MUL_B_W-1 -: nbge_pkg::MUL_DIGIT_W];
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(nbge_pkg::MUL_STEPS);
        a_r  <= req.a;
        b_r  <= req.b;
        acc  <= '0;
      end else if (busy) begin
        acc <= (acc << nbge_pkg::MUL_DIGIT_W) + nbge_pkg::MUL_P_W'(part);
        b_r <= b_r << nbge_pkg::MUL_DIGIT_W;
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/nbge_div.sv
// Shared restoring divider: one quotient bit per cycle, saturating quotient.
module nbge_div (
  input  logic                           clk,
  input  logic                           rst,
  input  nbge_pkg::div_req_t             req,
  output logic                           done,
  output logic [nbge_pkg::DIV_Q_W-1:0]   quo
);

  localparam int N_W   = nbge_pkg::DIV_N_W;
  localparam int D_W   = nbge_pkg::DIV_D_W;
  localparam int Q_W   = nbge_pkg::DIV_Q_W;
  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [N_W-1:0]   num;
  logic [D_W-1:0]   den;
  logic [D_W-1:0]   rem;
  logic [Q_W-1:0]   q;
  logic             sat;
  logic [D_W:0]     rem_sh;
  logic [D_W:0]     rem_diff;
  logic             ge;

  // Trial subtraction for the next quotient bit.
  assign rem_sh   = {rem, num[N_W-1]};
  assign ge       = (rem_sh >= {1'b0, den});
  assign rem_diff = rem_sh - {1'b0, den};
  assign quo      = sat ? '1 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N_W);
        num  <= req.num;
        den  <= req.den;
        rem  <= '0;
        q    <= '0;
        sat  <= 1'b0;
      end else if (busy) begin
        rem <= ge ? rem_diff[D_W-1:0] : rem_sh[D_W-1:0];
        num <= {num[N_W-2:0], 1'b0};
        q   <= {q[Q_W-2:0], ge};
        // A bit shifted out of the quotient means it does not fit.
        sat <= sat | q[Q_W-1];
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");

endmodule

### hw/rtl/nbge_root.sv
// Integer square root, two radicand bits per cycle.
module nbge_root (
  input  logic                            clk,
  input  logic                            rst,
  input  nbge_pkg::root_req_t             req,
  output logic                            done,
  output logic [nbge_pkg::ROOT_W-1:0]     root
);

  localparam int STEPS = (nbge_pkg::ROOT_V_W + 1) / 2;
  localparam int V_W   = 2 * STEPS;
  localparam int R_W   = STEPS;
  localparam int REM_W = R_W + 1;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [V_W-1:0]   v;
  logic [R_W-1:0]   res;
  logic [REM_W-1:0] rem;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] rem_diff;
  logic             ge;

  // Bring down the next pair of bits and try a one.
  assign rem_sh   = {rem, v[V_W-1 -: 2]};
  assign trial    = (REM_W + 2)'({res, 2'b01});
  assign ge       = (rem_sh >= trial);
  assign rem_diff = rem_sh - trial;
  assign root     = res[nbge_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS);
        v    <= V_W'(req.val);
        res  <= '0;
        rem  <= '0;
      end else if (busy) begin
        rem <= ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        res <= {res[R_W-2:0], ge};
        v   <= v << 2;
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/nbge_back.sv
// Back end: holds the target body, sums forces and performs the Euler update.
module nbge_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  nbge_pkg::item_t                   q_item,
  output logic                              q_pop,
  input  nbge_pkg::cfg_t                    cfg,
  input  logic                              pop,
  output logic                              empty,
  output nbge_pkg::update_t                 update,
  output nbge_pkg::mul_req_t                mul_req,
  input  logic                              mul_done,
  input  logic [nbge_pkg::MUL_P_W-1:0]      mul_prod,
  output nbge_pkg::div_req_t                div_req,
  input  logic                              div_done,
  input  logic [nbge_pkg::DIV_Q_W-1:0]      div_quo,
  output nbge_pkg::root_req_t               root_req,
  input  logic                              root_done,
  input  logic [nbge_pkg::ROOT_W-1:0]       root_val
);

  localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;
  localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
  localparam logic [48:0]        DV_CAP = 49'h1_0000_0000_0000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DELTA, ST_SQ_GO, ST_SQ_WAIT, ST_RT_GO, ST_RT_WAIT,
    ST_MP_GO, ST_MP_WAIT, ST_K_GO, ST_K_WAIT, ST_AX_CHK,
    ST_U_GO, ST_U_WAIT, ST_KU_GO, ST_KU_WAIT, ST_F_GO, ST_F_WAIT, ST_ACC,
    ST_UPD, ST_FT_GO, ST_FT_WAIT, ST_DV_GO, ST_DV_WAIT, ST_VT_GO, ST_VT_WAIT,
    ST_OUT
  } state_t;

  state_t                    state;
  logic [1:0]                ax;
  nbge_pkg::item_t           cur;
  logic signed [48:0]        dl [3];
  logic [97:0]               r2;
  logic [98:0]               r2e;
  logic [48:0]               distance;
  logic [63:0]               mp;
  logic [95:0]               k;
  logic [30:0]               u;
  logic [126:0]              ku;
  logic [63:0]               f;
  logic [87:0]               ft;
  logic signed [47:0]        tp [3];
  logic signed [47:0]        tv [3];
  logic [31:0]               tm;
  logic signed [63:0]        fs [3];
  nbge_pkg::update_t         res;
  logic                      res_valid;

  logic signed [48:0]        dl_sel;
  logic [47:0]               dl_mag;
  logic signed [63:0]        fs_sel;
  logic [63:0]               fs_mag;
  logic signed [47:0]        tv_sel;
  logic [47:0]               tv_mag;
  logic [97:0]               r2_sum;
  logic signed [63:0]        f_cap;
  logic signed [63:0]        f_sgn;
  logic signed [64:0]        fs_add;
  logic signed [63:0]        fs_new;
  logic [48:0]               dv_cap;
  logic signed [49:0]        dv_ext;
  logic signed [49:0]        v_sum;
  logic signed [49:0]        dp_ext;
  logic signed [49:0]        p_sum;
  logic                      src_last;

  // Clamp a sum to the signed 48-bit range.
  function automatic logic signed [47:0] sat48(input logic signed [49:0] s);
    logic [2:0] top;
    top = s[49:47];
    if (top == 3'b000 || top == 3'b111) begin
      return s[47:0];
    end
    return s[49] ? MIN48 : MAX48;
  endfunction

  // Per-axis operand selection and magnitudes.
  assign dl_sel   = dl[ax];
  assign dl_mag   = dl_sel[48] ? 48'(-dl_sel) : dl_sel[47:0];
  assign fs_sel   = fs[ax];
  assign fs_mag   = fs_sel[63] ? 64'(-fs_sel) : fs_sel;
  assign tv_sel   = tv[ax];
  assign tv_mag   = tv_sel[47] ? 48'(-tv_sel) : tv_sel;
  assign r2_sum   = r2 + mul_prod[97:0];
  assign src_last = (cur.kind == nbge_pkg::KIND_FINAL);

  // Force contribution, saturating accumulation.
  assign f_cap  = f[63] ? MAX64 : f;
  assign f_sgn  = dl_sel[48] ? -f_cap : f_cap;
  assign fs_add = {fs_sel[63], fs_sel} + {f_sgn[63], f_sgn};
  assign fs_new = (fs_add[64] != fs_add[63]) ? (fs_add[64] ? MIN64 : MAX64) : fs_add[63:0];

  // Velocity step with the change capped at 2^48.
  assign dv_cap = ((|div_quo[63:49]) || (div_quo[48] && (|div_quo[47:0]))) ?
                  DV_CAP : div_quo[48:0];
  assign dv_ext = 50'({1'b0, dv_cap});
  assign v_sum  = {{2{tv_sel[47]}}, tv_sel} + (fs_sel[63] ? -dv_ext : dv_ext);

  // Position step from the updated velocity.
  assign dp_ext = 50'({1'b0, mul_prod[71:24]});
  assign p_sum  = {{2{tp[ax][47]}}, tp[ax]} + (tv_sel[47] ? -dp_ext : dp_ext);

  assign q_pop  = (state == ST_IDLE) && !q_empty;
  assign empty  = !res_valid;
  assign update = res;

  // Requests to the shared arithmetic units.
  always_comb begin
    mul_req.start = state inside {ST_SQ_GO, ST_MP_GO, ST_K_GO, ST_KU_GO, ST_FT_GO, ST_VT_GO};
    mul_req.a     = '0;
    mul_req.b     = '0;
    case (state)
      ST_SQ_GO: begin
        mul_req.a = 96'(dl_mag);
        mul_req.b = 64'(dl_mag);
      end
      ST_MP_GO: begin
        mul_req.a = 96'(tm);
        mul_req.b = 64'(cur.mass);
      end
      ST_K_GO: begin
        mul_req.a = 96'(mp);
        mul_req.b = 64'(cfg.grav);
      end
      ST_KU_GO: begin
        mul_req.a = k;
        mul_req.b = 64'(u);
      end
      ST_FT_GO: begin
        mul_req.a = 96'(fs_mag);
        mul_req.b = 64'(cfg.step);
      end
      ST_VT_GO: begin
        mul_req.a = 96'(tv_mag);
        mul_req.b = 64'(cfg.step);
      end
      default: begin
        mul_req.a = '0;
      end
    endcase

    div_req.start = state inside {ST_U_GO, ST_F_GO, ST_DV_GO};
    div_req.num   = '0;
    div_req.den   = '0;
    case (state)
      ST_U_GO: begin
        div_req.num = 145'({dl_mag, 30'd0});
        div_req.den = 99'(distance);
      end
      ST_F_GO: begin
        div_req.num = {ku, 18'd0};
        div_req.den = r2e;
      end
      ST_DV_GO: begin
        div_req.num = 145'(ft);
        div_req.den = 99'({tm, 24'd0});
      end
      default: begin
        div_req.num = '0;
      end
    endcase

    root_req.start = (state == ST_RT_GO);
    root_req.val   = r2;
  end

  // Sequencer, target state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ax        <= '0;
      res_valid <= 1'b0;
      tm        <= '0;
      for (int a = 0; a < 3; a++) begin
        tp[a] <= '0;
        tv[a] <= '0;
        fs[a] <= '0;
      end
    end else begin
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            if (q_item.kind == nbge_pkg::KIND_LOAD) begin
              for (int a = 0; a < 3; a++) begin
                tp[a] <= q_item.pos[a];
                tv[a] <= q_item.vel[a];
                fs[a] <= '0;
              end
              tm <= q_item.mass;
            end else begin
              cur   <= q_item;
              state <= ST_DELTA;
            end
          end
        end
        ST_DELTA: begin
          for (int a = 0; a < 3; a++) begin
            dl[a] <= {cur.pos[a][47], cur.pos[a]} - {tp[a][47], tp[a]};
          end
          r2    <= '0;
          ax    <= '0;
          state <= ST_SQ_GO;
        end
        ST_SQ_GO: state <= ST_SQ_WAIT;
        ST_SQ_WAIT: begin
          if (mul_done) begin
            r2 <= r2_sum;
            if (ax == 2'd2) begin
              ax <= '0;
              // A source at the target's position adds nothing.
              if (r2_sum == '0) begin
                state <= src_last ? ST_UPD : ST_IDLE;
              end else begin
                state <= ST_RT_GO;
              end
            end else begin
              ax    <= ax + 1'b1;
              state <= ST_SQ_GO;
            end
          end
        end
        ST_RT_GO: state <= ST_RT_WAIT;
        ST_RT_WAIT: begin
          if (root_done) begin
            distance <= root_val;
            r2e      <= {1'b0, r2} + nbge_pkg::EPS_Q48;
            state    <= ST_MP_GO;
          end
        end
        ST_MP_GO: state <= ST_MP_WAIT;
        ST_MP_WAIT: begin
          if (mul_done) begin
            mp    <= mul_prod[63:0];
            state <= ST_K_GO;
          end
        end
        ST_K_GO: state <= ST_K_WAIT;
        ST_K_WAIT: begin
          if (mul_done) begin
            k     <= mul_prod[95:0];
            ax    <= '0;
            state <= ST_AX_CHK;
          end
        end
        ST_AX_CHK: begin
          // An axis with no offset gets no force.
          if (dl_sel == '0) begin
            if (ax == 2'd2) begin
              ax    <= '0;
              state <= src_last ? ST_UPD : ST_IDLE;
            end else begin
              ax <= ax + 1'b1;
            end
          end else begin
            state <= ST_U_GO;
          end
        end
        ST_U_GO: state <= ST_U_WAIT;
        ST_U_WAIT: begin
          if (div_done) begin
            u     <= div_quo[30:0];
            state <= ST_KU_GO;
          end
        end
        ST_KU_GO: state <= ST_KU_WAIT;
        ST_KU_WAIT: begin
          if (mul_done) begin
            ku    <= mul_prod[126:0];
            state <= ST_F_GO;
          end
        end
        ST_F_GO: state <= ST_F_WAIT;
        ST_F_WAIT: begin
          if (div_done) begin
            f     <= div_quo;
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          fs[ax] <= fs_new;
          if (ax == 2'd2) begin
            ax    <= '0;
            state <= src_last ? ST_UPD : ST_IDLE;
          end else begin
            ax    <= ax + 1'b1;
            state <= ST_AX_CHK;
          end
        end
        ST_UPD: begin
          // A massless target keeps its velocity.
          state <= (tm != '0) ? ST_FT_GO : ST_VT_GO;
        end
        ST_FT_GO: state <= ST_FT_WAIT;
        ST_FT_WAIT: begin
          if (mul_done) begin
            ft    <= mul_prod[87:0];
            state <= ST_DV_GO;
          end
        end
        ST_DV_GO: state <= ST_DV_WAIT;
        ST_DV_WAIT: begin
          if (div_done) begin
            tv[ax] <= sat48(v_sum);
            state  <= ST_VT_GO;
          end
        end
        ST_VT_GO: state <= ST_VT_WAIT;
        ST_VT_WAIT: begin
          if (mul_done) begin
            tp[ax] <= sat48(p_sum);
            fs[ax] <= '0;
            if (ax == 2'd2) begin
              ax    <= '0;
              state <= ST_OUT;
            end else begin
              ax    <= ax + 1'b1;
              state <= ST_UPD;
            end
          end
        end
        ST_OUT: begin
          if (!res_valid) begin
            res.new_x  <= tp[0];
            res.new_y  <= tp[1];
            res.new_z  <= tp[2];
            res.new_vx <= tv[0];
            res.new_vy <= tv[1];
            res.new_vz <= tv[2];
            res_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_OUT)
    else $error("result written outside the output step");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_req.start, div_req.start, root_req.start}))
    else $error("two arithmetic units started together");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    ax != 2'd3)
    else $error("axis index out of range");

endmodule

### hw/rtl/nbody_gravity_euler_step.sv
// Top level of the n-body gravity Euler step block.
//
//   channel   direction  handshake                 payload
//   body      in         push / full               body_t (command, position, velocity, mass)
//   update    out        empty / pop               update_t (new position and velocity)
//   config    in         psel/penable/pwrite/...   grav_const at 0x0, time_step at 0x4
//
// A load item replaces the target body and clears its force sums. The time for a source item is
// set mostly by the bit-serial divider: up to six divisions per source item, and up to three
// more when the item also triggers the update.
// Reset restores the register defaults and clears the target body and force sums.
// A queue of QUEUE_DEPTH items takes input while the back end works, and one
// finished result waits in the output register while the back end goes on.
module nbody_gravity_euler_step #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  nbge_pkg::body_t   body,
  output logic              empty,
  input  logic              pop,
  output nbge_pkg::update_t update,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  nbge_pkg::cfg_t                   cfg;
  nbge_pkg::item_t                  q_item;
  logic                             q_empty;
  logic                             q_pop;
  nbge_pkg::mul_req_t               mul_req;
  logic                             mul_done;
  logic [nbge_pkg::MUL_P_W-1:0]     mul_prod;
  nbge_pkg::div_req_t               div_req;
  logic                             div_done;
  logic [nbge_pkg::DIV_Q_W-1:0]     div_quo;
  nbge_pkg::root_req_t              root_req;
  logic                             root_done;
  logic [nbge_pkg::ROOT_W-1:0]      root_val;
  logic                             cfg_wr;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grav <= nbge_pkg::GRAV_RESET;
      cfg.step <= nbge_pkg::STEP_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        nbge_pkg::REG_GRAV: cfg.grav <= pwdata;
        nbge_pkg::REG_STEP: cfg.step <= pwdata[23:0];
        default: cfg.grav <= cfg.grav;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      nbge_pkg::REG_GRAV: prdata = cfg.grav;
      nbge_pkg::REG_STEP: prdata = {8'd0, cfg.step};
      default:            prdata = '0;
    endcase
  end

  nbge_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .body   (body),
    .q_pop  (q_pop),
    .q_empty(q_empty),
    .q_item (q_item)
  );

  nbge_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .done(mul_done),
    .prod(mul_prod)
  );

  nbge_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .done(div_done),
    .quo (div_quo)
  );

  nbge_root u_root (
    .clk (clk),
    .rst (rst),
    .req (root_req),
    .done(root_done),
    .root(root_val)
  );

  nbge_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .cfg      (cfg),
    .pop      (pop),
    .empty    (empty),
    .update   (update),
    .mul_req  (mul_req),
    .mul_done (mul_done),
    .mul_prod (mul_prod),
    .div_req  (div_req),
    .div_done (div_done),
    .div_quo  (div_quo),
    .root_req (root_req),
    .root_done(root_done),
    .root_val (root_val)
  );

endmodule
